### design/eatrm_pkg.sv
// ----------------------------------------------------------------------------
// eatrm_pkg: shared types and constants for the Euler angle rotation matrix
// Angle reduction constants, CORDIC table, stage record and rounding helpers.
// ----------------------------------------------------------------------------
package eatrm_pkg;

	localparam int TRIG_ITERATIONS_DEF = 16;
	localparam int TAB_LEN = 24;
	localparam int ANG_W = 20;
	localparam int OUT_W = 16;

	// CORDIC datapath widths (Q30 values, z in 2^-22 degree)
	localparam int XY_W = 33;
	localparam int Z_W = 34;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
	localparam logic signed [21:0] ANG_TURN = 22'sd368640;
	localparam logic signed [21:0] ANG_HALF = 22'sd184320;
	localparam logic signed [21:0] ANG_QUARTER = 22'sd92160;

	// atan(2^-i) in units of 2^-22 degree
	function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] idx);
		logic signed [Z_W-1:0] r;
		begin
			unique case (idx)
				5'd0: r = 34'sd188743680;
				5'd1: r = 34'sd111421900;
				5'd2: r = 34'sd58872272;
				5'd3: r = 34'sd29884485;
				5'd4: r = 34'sd15000234;
				5'd5: r = 34'sd7507429;
				5'd6: r = 34'sd3754631;
				5'd7: r = 34'sd1877430;
				5'd8: r = 34'sd938729;
				5'd9: r = 34'sd469366;
				5'd10: r = 34'sd234683;
				5'd11: r = 34'sd117342;
				5'd12: r = 34'sd58671;
				5'd13: r = 34'sd29335;
				5'd14: r = 34'sd14668;
				5'd15: r = 34'sd7334;
				5'd16: r = 34'sd3667;
				5'd17: r = 34'sd1833;
				5'd18: r = 34'sd917;
				5'd19: r = 34'sd458;
				5'd20: r = 34'sd229;
				5'd21: r = 34'sd115;
				5'd22: r = 34'sd57;
				5'd23: r = 34'sd29;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// one rotator's working set
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
		logic neg;
	} rot_t;

	// the three rotators plus the pass-through flag
	typedef struct packed {
		rot_t a1;
		rot_t a2;
		rot_t a3;
		logic last;
	} trio_t;

	// Q30 product rounded to nearest, half up
	function automatic logic signed [XY_W-1:0] mulq30(input logic signed [XY_W-1:0] a,
		input logic signed [XY_W-1:0] b);
		logic signed [2*XY_W-1:0] p;
		begin
			p = a * b + (66'sd1 <<< 29);
			return p[XY_W+29:30];
		end
	endfunction

	// Q30 to Q14 with saturation at one
	function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [XY_W+1:0] v);
		logic signed [XY_W+1:0] q;
		begin
			q = (v + 35'sd32768) >>> 16;
			if (q > 35'sd16384) return 16'sd16384;
			else if (q < -35'sd16384) return -16'sd16384;
			else return q[OUT_W-1:0];
		end
	endfunction

endpackage

### design/eatrm_cell.sv
// ----------------------------------------------------------------------------
// eatrm_cell: one CORDIC micro-rotation stage for three angles
// Applies step IDX (or passes through) to each rotator, then registers.
// ----------------------------------------------------------------------------
module eatrm_cell #(
	parameter int IDX = 0,
	parameter bit ACTIVE = 1'b1
) (
	input  logic             clk,
	input  logic             en,
	input  eatrm_pkg::trio_t d,
	output eatrm_pkg::trio_t q
);

	function automatic eatrm_pkg::rot_t step(input eatrm_pkg::rot_t r);
		eatrm_pkg::rot_t o;
		logic signed [eatrm_pkg::XY_W-1:0] dx;
		logic signed [eatrm_pkg::XY_W-1:0] dy;
		logic signed [eatrm_pkg::Z_W-1:0] t;
		begin
			o = r;
			dx = r.y >>> IDX;
			dy = r.x >>> IDX;
			t = eatrm_pkg::atan_tab(5'(IDX));
			if (ACTIVE) begin
				if (!r.z[eatrm_pkg::Z_W-1]) begin
					o.x = r.x - dx;
					o.y = r.y + dy;
					o.z = r.z - t;
				end else begin
					o.x = r.x + dx;
					o.y = r.y - dy;
					o.z = r.z + t;
				end
			end
			return o;
		end
	endfunction

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			q.a1 <= step(d.a1);
			q.a2 <= step(d.a2);
			q.a3 <= step(d.a3);
			q.last <= d.last;
		end
	end

endmodule

### design/euler_angles_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix: three angles to a Q2.14 rotation matrix
// Angle reduction, a chain of CORDIC cells, two product stages and a sum stage.
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// in      | in_valid in_ready lon/lat/roll_angle last_item | into block
// out     | out_valid out_ready m00..m22 last_out     | out of block
//
// Fully pipelined, one beat per cycle while the output is not stalled. The
// stages are the reduction stage, one cell per CORDIC table entry, two
// product stages and the sum stage that loads the output register. The
// pipeline advances as a whole when the output register is empty or being
// taken. Reset clears only the stage valid bits.
module euler_angles_to_rotation_matrix #(
	parameter int TRIG_ITERATIONS = eatrm_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [19:0] lon_angle,
	input  logic signed [19:0] lat_angle,
	input  logic signed [19:0] roll_angle,
	input  logic last_item,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic last_out
);

	localparam int NC = eatrm_pkg::TAB_LEN;
	localparam int NV = NC + 4;
	localparam int W = eatrm_pkg::XY_W;

	logic [NV-1:0] vld_q;
	logic adv;

	// whole pipeline moves when the last stage can drain
	assign adv = !vld_q[NV-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NV-2:0], in_valid};
	end

	// wrap to [-180,180), fold to [-90,90]
	function automatic eatrm_pkg::rot_t reduce(input logic signed [19:0] a);
		eatrm_pkg::rot_t o;
		logic signed [21:0] r;
		begin
			r = 22'(a);
			if (r >= eatrm_pkg::ANG_TURN) r = r - eatrm_pkg::ANG_TURN;
			else if (r < -eatrm_pkg::ANG_TURN) r = r + eatrm_pkg::ANG_TURN;
			if (r < 0) r = r + eatrm_pkg::ANG_TURN;
			if (r >= eatrm_pkg::ANG_HALF) r = r - eatrm_pkg::ANG_TURN;
			o.neg = 1'b0;
			if (r > eatrm_pkg::ANG_QUARTER) begin
				r = r - eatrm_pkg::ANG_HALF;
				o.neg = 1'b1;
			end else if (r < -eatrm_pkg::ANG_QUARTER) begin
				r = r + eatrm_pkg::ANG_HALF;
				o.neg = 1'b1;
			end
			o.x = eatrm_pkg::CORDIC_GAIN_Q30;
			o.y = '0;
			o.z = eatrm_pkg::Z_W'(r) <<< 12;
			return o;
		end
	endfunction

	eatrm_pkg::trio_t chain [NC+1];

	// reduction stage
	always_ff @(posedge clk) begin
		if (adv) begin
			chain[0].a1 <= reduce(lon_angle);
			chain[0].a2 <= reduce(lat_angle);
			chain[0].a3 <= reduce(roll_angle);
			chain[0].last <= last_item;
		end
	end

	// CORDIC cells; those past the iteration count pass through
	for (genvar i = 0; i < NC; i++) begin : g_cell
		eatrm_cell #(.IDX(i), .ACTIVE(i < TRIG_ITERATIONS)) u_cell (
			.clk(clk), .en(adv), .d(chain[i]), .q(chain[i+1]));
	end

	// sign fix-up
	logic signed [W-1:0] c1, s1, c2, s2, c3, s3;
	always_comb begin
		c1 = chain[NC].a1.neg ? -chain[NC].a1.x : chain[NC].a1.x;
		s1 = chain[NC].a1.neg ? -chain[NC].a1.y : chain[NC].a1.y;
		c2 = chain[NC].a2.neg ? -chain[NC].a2.x : chain[NC].a2.x;
		s2 = chain[NC].a2.neg ? -chain[NC].a2.y : chain[NC].a2.y;
		c3 = chain[NC].a3.neg ? -chain[NC].a3.x : chain[NC].a3.x;
		s3 = chain[NC].a3.neg ? -chain[NC].a3.y : chain[NC].a3.y;
	end

	// first products
	logic signed [W-1:0] c1s2_s1, s1s2_s1, s1c3_s1, s1s3_s1, c1c2_s1, c1c3_s1;
	logic signed [W-1:0] c1s3_s1, s1c2_s1, c2s3_s1, c2c3_s1, s2_s1, c3_s1, s3_s1;
	logic last_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			c1s2_s1 <= eatrm_pkg::mulq30(c1, s2);
			s1s2_s1 <= eatrm_pkg::mulq30(s1, s2);
			s1c3_s1 <= eatrm_pkg::mulq30(s1, c3);
			s1s3_s1 <= eatrm_pkg::mulq30(s1, s3);
			c1c2_s1 <= eatrm_pkg::mulq30(c1, c2);
			c1c3_s1 <= eatrm_pkg::mulq30(c1, c3);
			c1s3_s1 <= eatrm_pkg::mulq30(c1, s3);
			s1c2_s1 <= eatrm_pkg::mulq30(s1, c2);
			c2s3_s1 <= eatrm_pkg::mulq30(c2, s3);
			c2c3_s1 <= eatrm_pkg::mulq30(c2, c3);
			s2_s1 <= s2;
			c3_s1 <= c3;
			s3_s1 <= s3;
			last_s1 <= chain[NC].last;
		end
	end

	// second products
	logic signed [W-1:0] p0_s2, p1_s2, p3_s2, p4_s2;
	logic signed [W-1:0] s1c3_s2, s1s3_s2, c1c2_s2, c1c3_s2, c1s3_s2, s1c2_s2;
	logic signed [W-1:0] c2s3_s2, c2c3_s2, s2_s2;
	logic last_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s2 <= eatrm_pkg::mulq30(c1s2_s1, s3_s1);
			p1_s2 <= eatrm_pkg::mulq30(c1s2_s1, c3_s1);
			p3_s2 <= eatrm_pkg::mulq30(s1s2_s1, s3_s1);
			p4_s2 <= eatrm_pkg::mulq30(s1s2_s1, c3_s1);
			s1c3_s2 <= s1c3_s1;
			s1s3_s2 <= s1s3_s1;
			c1c2_s2 <= c1c2_s1;
			c1c3_s2 <= c1c3_s1;
			c1s3_s2 <= c1s3_s1;
			s1c2_s2 <= s1c2_s1;
			c2s3_s2 <= c2s3_s1;
			c2c3_s2 <= c2c3_s1;
			s2_s2 <= s2_s1;
			last_s2 <= last_s1;
		end
	end

	// sums, rounding and saturation into the output register
	localparam int SW = W + 2;
	always_ff @(posedge clk) begin
		if (adv) begin
			m00 <= eatrm_pkg::to_q14(-SW'(s1c3_s2) - SW'(p0_s2));
			m01 <= eatrm_pkg::to_q14(SW'(s1s3_s2) - SW'(p1_s2));
			m02 <= eatrm_pkg::to_q14(SW'(c1c2_s2));
			m10 <= eatrm_pkg::to_q14(SW'(c1c3_s2) - SW'(p3_s2));
			m11 <= eatrm_pkg::to_q14(-SW'(c1s3_s2) - SW'(p4_s2));
			m12 <= eatrm_pkg::to_q14(SW'(s1c2_s2));
			m20 <= eatrm_pkg::to_q14(SW'(c2s3_s2));
			m21 <= eatrm_pkg::to_q14(SW'(c2c3_s2));
			m22 <= eatrm_pkg::to_q14(SW'(s2_s2));
			last_out <= last_s2;
		end
	end

	// checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(last_out))
		else $error("result changed while stalled");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m22 <= 16'sd16384 && m22 >= -16'sd16384)
		else $error("entry out of range");

endmodule

### verif/tb_euler_angles_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_matrix: self-checking bench for the angle block
// Drives angle triples with random gaps, predicts each Q2.14 matrix with a
// local CORDIC model and compares every output beat field by field.
// ----------------------------------------------------------------------------
module tb_euler_angles_to_rotation_matrix;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ITER = 16;
	localparam int PIPE_DEPTH = 28;
	localparam logic signed [19:0] ANG_MIN = -20'sd368640;
	localparam logic signed [19:0] ANG_MAX = 20'sd368639;

	typedef struct {
		logic signed [15:0] m [9];
		logic last;
	} matrix_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [19:0] lon_angle;
	logic signed [19:0] lat_angle;
	logic signed [19:0] roll_angle;
	logic last_item;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic last_out;

	matrix_t matrix_q[$];
	int err_cnt;
	bit drain_hold;

	euler_angles_to_rotation_matrix #(.TRIG_ITERATIONS(NUM_ITER)) u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.lon_angle(lon_angle), .lat_angle(lat_angle), .roll_angle(roll_angle),
		.last_item(last_item), .out_valid(out_valid), .out_ready(out_ready),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22), .last_out(last_out)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// arithmetic shift right, floor
	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return floor_shr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic signed [15:0] round_q14(input longint v);
		longint q;
		q = floor_shr(v + 32768, 16);
		if (q > 16384) q = 16384;
		if (q < -16384) q = -16384;
		return q[15:0];
	endfunction

	function automatic longint arctan_step(input int i);
		longint t [24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
			7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
		return t[i];
	endfunction

	// cosine and sine in Q30 by CORDIC rotation
	task automatic cos_sin(input logic signed [19:0] ang, output longint c,
		output longint s);
		longint r, x, y, z, dx, dy;
		bit flip;
		int n;
		r = longint'(ang) % 368640;
		flip = 0;
		if (r < 0) r += 368640;
		if (r >= 184320) r -= 368640;
		if (r > 92160) begin
			r -= 184320;
			flip = 1;
		end else if (r < -92160) begin
			r += 184320;
			flip = 1;
		end
		n = (NUM_ITER > 24) ? 24 : NUM_ITER;
		x = 652032874;
		y = 0;
		z = r * 4096;
		for (int i = 0; i < n; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_step(i);
			end else begin
				x += dx; y -= dy; z += arctan_step(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_matrix(input logic signed [19:0] lon,
		input logic signed [19:0] lat, input logic signed [19:0] roll,
		input logic lst, output matrix_t e);
		longint c1, s1, c2, s2, c3, s3, c1s2, s1s2;
		cos_sin(lon, c1, s1);
		cos_sin(lat, c2, s2);
		cos_sin(roll, c3, s3);
		c1s2 = q30_mul(c1, s2);
		s1s2 = q30_mul(s1, s2);
		e.m[0] = round_q14(-q30_mul(s1, c3) - q30_mul(c1s2, s3));
		e.m[1] = round_q14(q30_mul(s1, s3) - q30_mul(c1s2, c3));
		e.m[2] = round_q14(q30_mul(c1, c2));
		e.m[3] = round_q14(q30_mul(c1, c3) - q30_mul(s1s2, s3));
		e.m[4] = round_q14(-q30_mul(c1, s3) - q30_mul(s1s2, c3));
		e.m[5] = round_q14(q30_mul(s1, c2));
		e.m[6] = round_q14(q30_mul(c2, s3));
		e.m[7] = round_q14(q30_mul(c2, c3));
		e.m[8] = round_q14(s2);
		e.last = lst;
	endtask

	// send one beat after a random gap; expectation queued on acceptance
	task automatic send_angles(input logic signed [19:0] lon,
		input logic signed [19:0] lat, input logic signed [19:0] roll,
		input logic lst);
		matrix_t e;
		int gap;
		gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		lon_angle <= lon;
		lat_angle <= lat;
		roll_angle <= roll;
		last_item <= lst;
		do @(posedge clk); while (!in_ready);
		predict_matrix(lon, lat, roll, lst, e);
		matrix_q.push_back(e);
		@(negedge clk);
	endtask

	function automatic logic signed [19:0] any_angle();
		return 20'($urandom_range(0, 20'hFFFFF));
	endfunction

	// sink stall pattern: redrawn per beat, with stretches of full rate
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = drain_hold ? 0 : $urandom_range(0, 11);
			if (($urandom % 3) == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// result checker
	always @(posedge clk) begin
		logic signed [15:0] got [9];
		matrix_t e;
		if (arst_n && out_valid && out_ready) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (matrix_q.size() == 0) begin
				$display("%0t: unexpected beat m00=%0d", $realtime, m00);
				err_cnt++;
			end else begin
				e = matrix_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== e.m[k]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $realtime,
							k / 3, k % 3, e.m[k], got[k]);
						err_cnt++;
					end
				if (last_out !== e.last) begin
					$display("%0t: last_out expected %0b actual %0b", $realtime,
						e.last, last_out);
					err_cnt++;
				end
			end
		end
	end

	// drop valid and wait until every queued result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (matrix_q.size() != 0);
	endtask

	// field extremes, quadrant edges, wrap beyond a turn, saturation
	task automatic test_directed();
		logic signed [19:0] edges [12] = '{20'sd0, ANG_MIN, ANG_MAX, 20'sd92160,
			-20'sd92160, 20'sd92161, 20'sd184320, -20'sd184320, 20'sd184319,
			20'sd276480, 20'sd1, -20'sd1};
		for (int i = 0; i < 12; i++)
			send_angles(edges[i], edges[(i + 5) % 12], edges[(i + 9) % 12], i[0]);
		send_angles(20'sd92160, 20'sd92160, 20'sd92160, 1'b1);
		send_angles(-20'sd184320, 20'sd0, 20'sd92160, 1'b0);
		send_angles(20'sh7FFFF, 20'sh80000, 20'sh55555, 1'b1);
		send_angles(20'shAAAAA, 20'sh7FFFF, 20'sh80000, 1'b0);
		send_angles(20'sd46080, 20'sd30720, -20'sd15360, 1'b1);
	endtask

	// full pause until the pipe empties, then back-to-back beats
	task automatic test_drain_pause();
		wait_drained();
		drain_hold = 1;
		for (int i = 0; i < 40; i++) begin
			in_valid <= 1'b1;
			lon_angle <= any_angle();
			lat_angle <= any_angle();
			roll_angle <= any_angle();
			last_item <= 1'($urandom_range(0, 1));
			do @(posedge clk); while (!in_ready);
			begin
				matrix_t e;
				predict_matrix(lon_angle, lat_angle, roll_angle, last_item, e);
				matrix_q.push_back(e);
			end
			@(negedge clk);
		end
		drain_hold = 0;
	endtask

	// random triples, mostly in the legal range, some near quadrant edges
	task automatic test_random(input int n);
		logic signed [19:0] a [3];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++)
				case ($urandom % 4)
					0: a[k] = any_angle();
					1: a[k] = 20'(92160 * int'($urandom_range(0, 7)) - 368640 +
						int'($urandom_range(0, 4)) - 2);
					default: a[k] = 20'(int'($urandom_range(0, 737279)) - 368640);
				endcase
			send_angles(a[0], a[1], a[2], 1'($urandom_range(0, 1)));
		end
	endtask

	// stimulus
	initial begin
		err_cnt = 0;
		drain_hold = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		lon_angle = '0;
		lat_angle = '0;
		roll_angle = '0;
		last_item = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_drain_pause();
		test_random(1750);
		wait_drained();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (err_cnt == 0 && matrix_q.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

### sim.f
design/eatrm_pkg.sv
design/eatrm_cell.sv
design/euler_angles_to_rotation_matrix.sv
verif/tb_euler_angles_to_rotation_matrix.sv
